@@ rtl/core/sdce_pkg.sv @@
// ---------------------------------------------------------------------------
// sdce_pkg
// Shared types, phase codes and command framing for the SD SPI command engine.
// ---------------------------------------------------------------------------
package sdce_pkg;

  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DESEL    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_READY    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_FAILDESEL = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SEND     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STUFF    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_RESP     = 3'd6;

  localparam logic [0:0] REG_READY_LIMIT = 1'b0;
  localparam logic [0:0] REG_RESP_LIMIT  = 1'b1;

  localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0]  CMD_SEND_IF   = 6'd8;
  localparam logic [5:0]  CMD_STOP      = 6'd12;
  localparam logic [5:0]  CMD_APP       = 6'd55;

  localparam logic [7:0]  CRC_GO_IDLE   = 8'h95;
  localparam logic [7:0]  CRC_SEND_IF   = 8'h87;
  localparam logic [7:0]  CRC_OTHER     = 8'h01;
  localparam logic [7:0]  IDLE_BYTE     = 8'hFF;

  localparam logic [15:0] READY_LIMIT_RST = 16'hFFFE;
  localparam logic [7:0]  RESP_LIMIT_RST  = 8'd32;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [2:0]         byte_count;
    logic [15:0]        poll_count;
    logic [5:0]         held_command;
    logic [31:0]        held_argument;
    logic               app_pending;
    logic               cs_active;
  } eng_state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       select_card;
    logic       done_res;
    logic [7:0] response;
    logic       ready_timeout;
  } eng_result_t;

  typedef struct packed {
    logic [15:0] ready_poll_limit;
    logic [7:0]  response_poll_limit;
  } eng_cfg_t;

  function automatic logic [7:0] frame_byte(input logic [5:0]  cmd,
                                            input logic [31:0] arg,
                                            input logic        app,
                                            input logic [2:0]  idx);
    logic [5:0]  c;
    logic [31:0] a;
    logic [7:0]  b;
    c = app ? CMD_APP : cmd;
    a = app ? 32'd0 : arg;
    case (idx)
      3'd0: b = {2'b01, c};
      3'd1: b = a[31:24];
      3'd2: b = a[23:16];
      3'd3: b = a[15:8];
      3'd4: b = a[7:0];
      default: begin
        if (c == CMD_GO_IDLE)      b = CRC_GO_IDLE;
        else if (c == CMD_SEND_IF) b = CRC_SEND_IF;
        else                       b = CRC_OTHER;
      end
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/sdce_cfg.sv @@
// ---------------------------------------------------------------------------
// sdce_cfg
// Poll limit registers, written through the plain configuration port.
// ---------------------------------------------------------------------------
module sdce_cfg import sdce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output eng_cfg_t    cfg_o
);

  eng_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_poll_limit    <= READY_LIMIT_RST;
      cfg_r.response_poll_limit <= RESP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_READY_LIMIT: cfg_r.ready_poll_limit    <= cfg_wdata;
        REG_RESP_LIMIT:  cfg_r.response_poll_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

@@ rtl/core/sdce_step.sv @@
// ---------------------------------------------------------------------------
// sdce_step
// Per-request sequencing: next engine state and the result for one byte slot.
// ---------------------------------------------------------------------------
module sdce_step import sdce_pkg::*; (
  input  logic        func,
  input  logic [5:0]  cmd_index,
  input  logic        app_cmd,
  input  logic [31:0] argument,
  input  logic [7:0]  rx_byte,
  input  eng_state_t  st,
  input  eng_cfg_t    cfg,
  output eng_state_t  st_nxt,
  output eng_result_t res
);

  always_comb begin
    eng_state_t  n;
    logic        start_cmd;
    logic [7:0]  tx;
    logic        done;
    logic [7:0]  rsp;
    logic        tmo;
    logic [5:0]  cur;
    n         = st;
    start_cmd = 1'b0;
    tx        = IDLE_BYTE;
    done      = 1'b0;
    rsp       = 8'd0;
    tmo       = 1'b0;
    cur       = 6'd0;
    if (!func) begin
      n.held_command  = cmd_index;
      n.app_pending   = app_cmd;
      n.held_argument = argument;
      n.byte_count    = 3'd0;
      n.poll_count    = 16'd0;
      start_cmd       = 1'b1;
    end else begin
      unique case (st.phase)
        PH_DESEL: begin
          n.cs_active  = 1'b1;
          n.poll_count = 16'd1;
          n.phase      = PH_READY;
        end
        PH_READY: begin
          if (rx_byte == IDLE_BYTE) begin
            n.phase      = PH_SEND;
            n.byte_count = 3'd0;
            tx = frame_byte(st.held_command, st.held_argument, st.app_pending, 3'd0);
          end else if (st.poll_count < cfg.ready_poll_limit) begin
            n.poll_count = st.poll_count + 16'd1;
          end else begin
            n.cs_active = 1'b0;
            n.phase     = PH_FAILDESEL;
          end
        end
        PH_FAILDESEL: begin
          n.phase       = PH_IDLE;
          n.app_pending = 1'b0;
          tx            = 8'd0;
          done          = 1'b1;
          rsp           = 8'hFF;
          tmo           = 1'b1;
        end
        PH_SEND: begin
          cur = st.app_pending ? CMD_APP : st.held_command;
          if (st.byte_count < 3'd5) begin
            n.byte_count = st.byte_count + 3'd1;
            tx = frame_byte(st.held_command, st.held_argument, st.app_pending,
                            n.byte_count);
          end else if (cur == CMD_STOP) begin
            n.phase = PH_STUFF;
          end else begin
            n.phase      = PH_RESP;
            n.poll_count = 16'd1;
          end
        end
        PH_STUFF: begin
          n.phase      = PH_RESP;
          n.poll_count = 16'd1;
        end
        PH_RESP: begin
          if (rx_byte[7] && (st.poll_count < {8'd0, cfg.response_poll_limit})) begin
            n.poll_count = st.poll_count + 16'd1;
          end else if (st.app_pending && (rx_byte <= 8'd1)) begin
            n.app_pending = 1'b0;
            n.byte_count  = 3'd0;
            n.poll_count  = 16'd0;
            start_cmd     = 1'b1;
          end else begin
            n.phase       = PH_IDLE;
            n.app_pending = 1'b0;
            tx            = 8'd0;
            done          = 1'b1;
            rsp           = rx_byte;
          end
        end
        default: begin
          n.phase = PH_IDLE;
        end
      endcase
    end
    if (start_cmd) begin
      cur = n.app_pending ? CMD_APP : n.held_command;
      if (cur == CMD_STOP) begin
        n.phase      = PH_SEND;
        n.byte_count = 3'd0;
        tx = frame_byte(n.held_command, n.held_argument, n.app_pending, 3'd0);
      end else begin
        n.phase     = PH_DESEL;
        n.cs_active = 1'b0;
      end
    end
    st_nxt            = n;
    res.tx_byte       = tx;
    res.select_card   = n.cs_active;
    res.done_res      = done;
    res.response      = rsp;
    res.ready_timeout = tmo;
  end

endmodule

@@ rtl/core/sd_spi_command_engine_top.sv @@
// ---------------------------------------------------------------------------
// sd_spi_command_engine_top
// SD card SPI-mode command engine, one request per SPI byte exchange.
// ---------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_ready   | func, cmd_index, app_cmd, argument, rx_byte
//  out     | out_valid / out_ready | tx_byte, select_card, done_res, response,
//          |                       | ready_timeout
//  cfg     | cfg_we                | cfg_index, cfg_wdata
//
// One request per cycle while in_ready is high; the result appears in the
// cycle after acceptance. The engine state and the result register both load
// at acceptance, so the next request sees the updated state straight away.
// in_ready is low only while a result is held and out_ready is low.
// Reset: engine idle, card deselected, poll limits 65534 and 32.
// ---------------------------------------------------------------------------
module sd_spi_command_engine_top import sdce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [5:0]  in_cmd_index,
  input  logic        in_app_cmd,
  input  logic [31:0] in_argument,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_select_card,
  output logic        out_done_res,
  output logic [7:0]  out_response,
  output logic        out_ready_timeout,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  eng_cfg_t    cfg;
  eng_state_t  st_r;
  eng_state_t  st_nxt;
  eng_result_t res_nxt;
  eng_result_t res_r;
  logic        out_valid_r;
  logic        in_acc;

  sdce_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  sdce_step u_step (
    .func      (in_func),
    .cmd_index (in_cmd_index),
    .app_cmd   (in_app_cmd),
    .argument  (in_argument),
    .rx_byte   (in_rx_byte),
    .st        (st_r),
    .cfg       (cfg),
    .st_nxt    (st_nxt),
    .res       (res_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase         <= PH_IDLE;
      st_r.byte_count    <= 3'd0;
      st_r.poll_count    <= 16'd0;
      st_r.held_command  <= 6'd0;
      st_r.held_argument <= 32'd0;
      st_r.app_pending   <= 1'b0;
      st_r.cs_active     <= 1'b0;
      out_valid_r        <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = res_r.tx_byte;
  assign out_select_card   = res_r.select_card;
  assign out_done_res      = res_r.done_res;
  assign out_response      = res_r.response;
  assign out_ready_timeout = res_r.ready_timeout;

`ifndef NO_ASSERTIONS
  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.ready_timeout |->
      res_r.done_res && (res_r.response == 8'hFF) && !res_r.select_card)
    else $error("ready timeout result malformed");

  a_ready_selected: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_READY) |-> st_r.cs_active)
    else $error("ready poll without card selected");

  a_idle_no_app: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> !st_r.app_pending)
    else $error("app command pending while idle");
`endif

endmodule

@@ tb/sv/sd_spi_command_engine_top_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sd_spi_command_engine_top_test
// Self-checking bench for the SD SPI command engine. A behavioural model of
// the engine runs beside the block and predicts every byte exchange. Start
// requests and card bytes are driven with random gaps, and the result side
// stalls at random. Both poll limits are swept, extremes included. Card
// bytes are chosen from the modelled phase, so that most commands run to
// completion, time out or are cut short by a new start.
// ---------------------------------------------------------------------------
module sd_spi_command_engine_top_test;
  import sdce_pkg::*;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic        func;
    logic [5:0]  cmd;
    logic        app;
    logic [31:0] arg;
    logic [7:0]  rx;
  } spi_request_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic [5:0]  in_cmd_index;
  logic        in_app_cmd;
  logic [31:0] in_argument;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_tx_byte;
  logic        out_select_card;
  logic        out_done_res;
  logic [7:0]  out_response;
  logic        out_ready_timeout;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  // modelled engine
  logic [PHASE_W-1:0] eng_phase;
  logic [2:0]         eng_bytes;
  logic [15:0]        eng_polls;
  logic [5:0]         eng_cmd;
  logic [31:0]        eng_arg;
  logic               eng_app;
  logic               eng_cs;
  eng_cfg_t           eng_limits;

  eng_result_t queued_replies[$];
  int unsigned fault_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold_cycles = 0;
  logic        tx_idle_on = 1'b1;
  logic        rx_idle_on = 1'b1;

  always #2 clk = ~clk;

  sd_spi_command_engine_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_cmd_index      (in_cmd_index),
    .in_app_cmd        (in_app_cmd),
    .in_argument       (in_argument),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_tx_byte       (out_tx_byte),
    .out_select_card   (out_select_card),
    .out_done_res      (out_done_res),
    .out_response      (out_response),
    .out_ready_timeout (out_ready_timeout),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  function automatic logic [5:0] live_cmd();
    return eng_app ? CMD_APP : eng_cmd;
  endfunction

  function automatic logic [7:0] frame_out(input logic [2:0] idx);
    logic [31:0] a;
    a = eng_app ? 32'd0 : eng_arg;
    if (idx == 3'd0) return {2'b01, live_cmd()};
    if (idx <= 3'd4) return a[8 * (4 - idx) +: 8];
    case (live_cmd())
      CMD_GO_IDLE: return CRC_GO_IDLE;
      CMD_SEND_IF: return CRC_SEND_IF;
      default:     return CRC_OTHER;
    endcase
  endfunction

  function automatic eng_result_t reply(input logic [7:0] tx, input logic done,
                                        input logic [7:0] res, input logic tout);
    eng_result_t r;
    r.tx_byte       = tx;
    r.select_card   = eng_cs;
    r.done_res      = done;
    r.response      = res;
    r.ready_timeout = tout;
    return r;
  endfunction

  function automatic eng_result_t filler();
    return reply(IDLE_BYTE, 1'b0, 8'd0, 1'b0);
  endfunction

  function automatic eng_result_t open_command();
    if (live_cmd() == CMD_STOP) begin
      eng_phase = PH_SEND;
      eng_bytes = 3'd0;
      return reply(frame_out(3'd0), 1'b0, 8'd0, 1'b0);
    end
    eng_phase = PH_DESEL;
    eng_cs    = 1'b0;
    return filler();
  endfunction

  function automatic eng_result_t close_command(input logic [7:0] res, input logic tout);
    eng_phase = PH_IDLE;
    eng_app   = 1'b0;
    return reply(8'd0, 1'b1, res, tout);
  endfunction

  function automatic eng_result_t spi_engine_step(input spi_request_t q);
    eng_result_t r;
    if (q.func == FUNC_START) begin
      eng_cmd   = q.cmd;
      eng_app   = q.app;
      eng_arg   = q.arg;
      eng_bytes = 3'd0;
      eng_polls = 16'd0;
      return open_command();
    end
    case (eng_phase)
      PH_DESEL: begin
        eng_cs    = 1'b1;
        eng_polls = 16'd1;
        eng_phase = PH_READY;
        r = filler();
      end
      PH_READY: begin
        if (q.rx == IDLE_BYTE) begin
          eng_phase = PH_SEND;
          eng_bytes = 3'd0;
          r = reply(frame_out(3'd0), 1'b0, 8'd0, 1'b0);
        end else if (eng_polls < eng_limits.ready_poll_limit) begin
          eng_polls = eng_polls + 16'd1;
          r = filler();
        end else begin
          eng_cs    = 1'b0;
          eng_phase = PH_FAILDESEL;
          r = filler();
        end
      end
      PH_FAILDESEL: r = close_command(IDLE_BYTE, 1'b1);
      PH_SEND: begin
        if (eng_bytes < 3'd5) begin
          eng_bytes = eng_bytes + 3'd1;
          r = reply(frame_out(eng_bytes), 1'b0, 8'd0, 1'b0);
        end else if (live_cmd() == CMD_STOP) begin
          eng_phase = PH_STUFF;
          r = filler();
        end else begin
          eng_phase = PH_RESP;
          eng_polls = 16'd1;
          r = filler();
        end
      end
      PH_STUFF: begin
        eng_phase = PH_RESP;
        eng_polls = 16'd1;
        r = filler();
      end
      PH_RESP: begin
        if (q.rx[7] && eng_polls < {8'd0, eng_limits.response_poll_limit}) begin
          eng_polls = eng_polls + 16'd1;
          r = filler();
        end else if (eng_app && q.rx > 8'd1) begin
          r = close_command(q.rx, 1'b0);
        end else if (eng_app) begin
          eng_app   = 1'b0;
          eng_bytes = 3'd0;
          eng_polls = 16'd0;
          r = open_command();
        end else begin
          r = close_command(q.rx, 1'b0);
        end
      end
      default: begin
        eng_phase = PH_IDLE;
        r = filler();
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
    fault_count++;
  endtask

  function automatic spi_request_t any_request(input logic func);
    spi_request_t q;
    q.func = func;
    q.cmd  = 6'($urandom_range(0, 63));
    q.app  = 1'($urandom_range(0, 1));
    q.arg  = $urandom;
    q.rx   = 8'($urandom_range(0, 255));
    return q;
  endfunction

  task automatic push_request(input spi_request_t q);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= q.func;
    in_cmd_index <= q.cmd;
    in_app_cmd   <= q.app;
    in_argument  <= q.arg;
    in_rx_byte   <= q.rx;
    do @(posedge clk); while (!(in_valid && in_ready));
    queued_replies.push_back(spi_engine_step(q));
  endtask

  task automatic start_command(input logic [5:0] cmd, input logic app,
                               input logic [31:0] arg);
    spi_request_t q;
    q = any_request(FUNC_START);
    q.cmd = cmd;
    q.app = app;
    q.arg = arg;
    push_request(q);
  endtask

  task automatic card_byte(input logic [7:0] rx);
    spi_request_t q;
    q = any_request(FUNC_BYTE);
    q.rx = rx;
    push_request(q);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (queued_replies.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_READY_LIMIT) eng_limits.ready_poll_limit = value;
    else eng_limits.response_poll_limit = value[7:0];
  endtask

  task automatic set_limits(input logic [15:0] ready_lim, input logic [7:0] resp_lim);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    settle();
    write_reg(REG_READY_LIMIT, ready_lim);
    write_reg(REG_RESP_LIMIT, {junk, resp_lim});
  endtask

  task automatic test_idle_bytes();
    card_byte(8'h00);
    card_byte(IDLE_BYTE);
  endtask

  // zero limits act as one poll; app command dies in the CMD55 ready wait
  task automatic test_never_ready();
    set_limits(16'd0, 8'd0);
    start_command(6'd41, 1'b1, 32'h4000_0000);
    card_byte(IDLE_BYTE);
    card_byte(8'h00);
    card_byte(8'h00);
  endtask

  task automatic test_stop_command();
    start_command(CMD_STOP, 1'b0, 32'hFFFF_FFFF);
    repeat (3) card_byte(8'h00);
    repeat (3) card_byte(IDLE_BYTE);
    card_byte(8'h3C);
    card_byte(8'hC0);
  endtask

  task automatic test_app_rejected();
    set_limits(16'hFFFF, 8'hFF);
    start_command(6'd63, 1'b1, 32'd0);
    card_byte(IDLE_BYTE);
    card_byte(8'h7F);
    card_byte(IDLE_BYTE);
    repeat (6) card_byte(8'hA5);
    card_byte(8'hFE);
    card_byte(8'h05);
  endtask

  // abandon a running CMD0 with an app-prefixed CMD8
  task automatic test_restart_and_app();
    start_command(CMD_GO_IDLE, 1'b0, $urandom);
    card_byte(8'h00);
    card_byte(IDLE_BYTE);
    start_command(CMD_SEND_IF, 1'b1, 32'h0000_01AA);
    card_byte(8'h00);
    card_byte(IDLE_BYTE);
    repeat (6) card_byte(8'h5A);
    card_byte(8'h01);
    card_byte(8'h00);
    card_byte(IDLE_BYTE);
    repeat (6) card_byte(8'h5A);
    card_byte(8'h00);
  endtask

  task automatic test_slow_card();
    set_limits(16'd300, 8'hFF);
    start_command(6'd17, 1'b0, $urandom);
    while (eng_phase != PH_IDLE) card_byte(8'h80 | 8'($urandom_range(0, 126)));
    start_command(6'd24, 1'b0, $urandom);
    while (eng_phase != PH_IDLE)
      card_byte(eng_phase == PH_READY ? IDLE_BYTE : 8'h80 | 8'($urandom_range(0, 126)));
  endtask

  task automatic test_backpressure();
    int unsigned round;
    settle();
    tx_idle_on = 1'b0;
    rx_hold_cycles = 64;
    for (round = 0; round < 3; round++) begin
      if (round == 2) settle();
      start_command(6'($urandom_range(0, 63)), 1'b0, $urandom);
      while (eng_phase != PH_IDLE) card_byte(eng_phase == PH_READY ? IDLE_BYTE : 8'h01);
    end
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    spi_request_t q;
    int unsigned  phase_no;
    int unsigned  n;
    logic [15:0]  ready_lim;
    logic [7:0]   resp_lim;
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      case ($urandom_range(0, 4))
        0:       ready_lim = 16'd0;
        1:       ready_lim = 16'd1;
        2:       ready_lim = 16'hFFFF;
        3:       ready_lim = 16'($urandom_range(0, 65535));
        default: ready_lim = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 4))
        0:       resp_lim = 8'd0;
        1:       resp_lim = 8'd1;
        2:       resp_lim = 8'hFF;
        3:       resp_lim = 8'($urandom_range(0, 255));
        default: resp_lim = 8'($urandom_range(2, 6));
      endcase
      set_limits(ready_lim, resp_lim);
      tx_idle_on = (phase_no % 4) != 1;
      rx_idle_on = (phase_no % 4) != 2;
      for (n = 0; n < 157; n++) begin
        q = any_request(FUNC_BYTE);
        if (eng_phase == PH_IDLE) begin
          if ($urandom_range(0, 9) != 0) q.func = FUNC_START;
        end else if ($urandom_range(0, 59) == 0) begin
          q.func = FUNC_START;
        end
        if (q.func == FUNC_START) begin
          case ($urandom_range(0, 5))
            0: q.cmd = CMD_GO_IDLE;
            1: q.cmd = CMD_SEND_IF;
            2: q.cmd = CMD_STOP;
            3: q.cmd = CMD_APP;
            default: ;
          endcase
          q.app = ($urandom_range(0, 3) == 0);
          case ($urandom_range(0, 7))
            0: q.arg = 32'd0;
            1: q.arg = 32'hFFFF_FFFF;
            default: ;
          endcase
        end else if (eng_phase == PH_READY) begin
          if ($urandom_range(0, 2) != 0) q.rx = IDLE_BYTE;
        end else if (eng_phase == PH_RESP && $urandom_range(0, 1) == 1) begin
          q.rx[7] = 1'b0;
          if (eng_app && $urandom_range(0, 3) != 0) q.rx = 8'($urandom_range(0, 1));
        end
        push_request(q);
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  always @(posedge clk) begin : reply_check
    eng_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (queued_replies.size() == 0) begin
        flag_mismatch("unrequested result", 32'(out_tx_byte), 32'd0);
      end else begin
        want = queued_replies.pop_front();
        if (out_tx_byte !== want.tx_byte)
          flag_mismatch("tx_byte", 32'(out_tx_byte), 32'(want.tx_byte));
        if (out_select_card !== want.select_card)
          flag_mismatch("select_card", 32'(out_select_card), 32'(want.select_card));
        if (out_done_res !== want.done_res)
          flag_mismatch("done_res", 32'(out_done_res), 32'(want.done_res));
        if (out_response !== want.response)
          flag_mismatch("response", 32'(out_response), 32'(want.response));
        if (out_ready_timeout !== want.ready_timeout)
          flag_mismatch("ready_timeout", 32'(out_ready_timeout), 32'(want.ready_timeout));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("sd_spi_command_engine_top_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_func      <= FUNC_START;
    in_cmd_index <= 6'd0;
    in_app_cmd   <= 1'b0;
    in_argument  <= 32'd0;
    in_rx_byte   <= 8'd0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_READY_LIMIT;
    cfg_wdata    <= 16'd0;
    eng_phase = PH_IDLE;
    eng_bytes = 3'd0;
    eng_polls = 16'd0;
    eng_cmd   = 6'd0;
    eng_arg   = 32'd0;
    eng_app   = 1'b0;
    eng_cs    = 1'b0;
    eng_limits.ready_poll_limit    = READY_LIMIT_RST;
    eng_limits.response_poll_limit = RESP_LIMIT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_never_ready();
    test_stop_command();
    test_app_rejected();
    test_restart_and_app();
    test_backpressure();
    test_random_traffic();
    test_slow_card();
    settle();
    repeat (4) @(posedge clk);
    if (fault_count == 0) begin
      $display("sd_spi_command_engine_top_test: done, clean");
    end else begin
      $display("sd_spi_command_engine_top_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sdce_pkg.sv
rtl/core/sdce_cfg.sv
rtl/core/sdce_step.sv
rtl/core/sd_spi_command_engine_top.sv
tb/sv/sd_spi_command_engine_top_test.sv
